// ----- rtl/assert_macros.svh -----
// Assertion shorthands for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define B64D_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("b64d check failed");

// Next-cycle implication, disabled while reset is asserted.
`define B64D_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("b64d check failed");

`endif

// ----- rtl/b64d_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package b64d_pkg;

	// Most results a single character can cause (one full group).
	localparam int MAX_RES   = 3;
	localparam int RES_CNT_W = 2;

	// Default result queue depth; keep it a power of two, at least four.
	localparam int FIFO_DEPTH_DEF = 8;

	localparam logic [7:0] CH_UPPER_A = 8'h41;
	localparam logic [7:0] CH_UPPER_Z = 8'h5A;
	localparam logic [7:0] CH_LOWER_A = 8'h61;
	localparam logic [7:0] CH_LOWER_Z = 8'h7A;
	localparam logic [7:0] CH_DIGIT_0 = 8'h30;
	localparam logic [7:0] CH_DIGIT_9 = 8'h39;
	localparam logic [7:0] CH_PLUS    = 8'h2B;
	localparam logic [7:0] CH_SLASH   = 8'h2F;

	// Offsets that map each alphabet range onto its sextet values.
	localparam logic [7:0] OFS_UPPER = 8'd65;  // 'A' -> 0
	localparam logic [7:0] OFS_LOWER = 8'd71;  // 'a' -> 26
	localparam logic [7:0] OFS_DIGIT = 8'd4;   // '0' -> 52, added
	localparam logic [5:0] SX_PLUS   = 6'd62;
	localparam logic [5:0] SX_SLASH  = 6'd63;

	typedef struct packed {
		logic       hit;
		logic [5:0] val;
	} sextet_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       byte_valid;
		logic       run_last;
		logic       stream_done;
	} res_t;

	typedef struct packed {
		logic [RES_CNT_W-1:0]  n_res;
		res_t [MAX_RES-1:0]    res;
	} dec_t;

	function automatic sextet_t sextet_lookup(input logic [7:0] c);
		sextet_t s;
		s = '0;
		if (c >= CH_UPPER_A && c <= CH_UPPER_Z) begin
			s.hit = 1'b1;
			s.val = 6'(c - OFS_UPPER);
		end else if (c >= CH_LOWER_A && c <= CH_LOWER_Z) begin
			s.hit = 1'b1;
			s.val = 6'(c - OFS_LOWER);
		end else if (c >= CH_DIGIT_0 && c <= CH_DIGIT_9) begin
			s.hit = 1'b1;
			s.val = 6'(c + OFS_DIGIT);
		end else if (c == CH_PLUS) begin
			s.hit = 1'b1;
			s.val = SX_PLUS;
		end else if (c == CH_SLASH) begin
			s.hit = 1'b1;
			s.val = SX_SLASH;
		end
		return s;
	endfunction

endpackage

`default_nettype wire

// ----- rtl/b64d_decode.sv -----
`timescale 1ns / 1ps
`default_nettype none

module b64d_decode (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          step,
	input  wire logic [7:0]    char_code,
	input  wire logic          last_char,
	output b64d_pkg::dec_t     dec
);
	import b64d_pkg::*;

	logic [5:0] held_q [3];
	logic [1:0] fill_q;
	logic       halted_q;

	sextet_t    lk;
	logic [5:0] held_new [3];
	logic [2:0] flush_fill;
	logic [7:0] b0, b1, b2;

	always_comb begin
		lk       = sextet_lookup(char_code);
		held_new = held_q;
		if (lk.hit && fill_q != 2'd3) begin
			held_new[fill_q] = lk.val;
		end
		// on a stop nothing is written, so one source serves both flush cases
		flush_fill = lk.hit ? 3'(fill_q) + 3'd1 : 3'(fill_q);
		b0 = {held_new[0], held_new[1][5:4]};
		b1 = {held_new[1][3:0], held_new[2][5:2]};
		b2 = {held_q[2][1:0], lk.val};
	end

	always_comb begin
		dec = '0;
		if (!halted_q) begin
			if (lk.hit && fill_q == 2'd3) begin
				dec.n_res = 2'd3;
				dec.res[0].data_byte = b0;
				dec.res[1].data_byte = b1;
				dec.res[2].data_byte = b2;
				dec.res[0].byte_valid = 1'b1;
				dec.res[1].byte_valid = 1'b1;
				dec.res[2].byte_valid = 1'b1;
			end else if (!lk.hit || last_char) begin
				// flush the partial group: n held values give n-1 bytes
				if (flush_fill >= 3'd2) begin
					dec.res[0].data_byte  = b0;
					dec.res[0].byte_valid = 1'b1;
					dec.n_res             = 2'd1;
				end
				if (flush_fill >= 3'd3) begin
					dec.res[1].data_byte  = b1;
					dec.res[1].byte_valid = 1'b1;
					dec.n_res             = 2'd2;
				end
			end
		end
		if (last_char) begin
			if (dec.n_res == 2'd0) begin
				dec.n_res = 2'd1;
			end
			dec.res[dec.n_res - 2'd1].stream_done = 1'b1;
		end
		if (dec.n_res != 2'd0) begin
			dec.res[dec.n_res - 2'd1].run_last = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q   <= '{default: '0};
			fill_q   <= '0;
			halted_q <= 1'b0;
		end else if (step) begin
			if (last_char) begin
				fill_q   <= '0;
				halted_q <= 1'b0;
			end else if (!halted_q) begin
				if (!lk.hit) begin
					fill_q   <= '0;
					halted_q <= 1'b1;
				end else if (fill_q == 2'd3) begin
					fill_q <= '0;
				end else begin
					held_q[fill_q] <= lk.val;
					fill_q         <= fill_q + 2'd1;
				end
			end
		end
	end

endmodule

`default_nettype wire

// ----- rtl/b64d_resq.sv -----
`timescale 1ns / 1ps
`default_nettype none

module b64d_resq #(
	parameter int DEPTH = b64d_pkg::FIFO_DEPTH_DEF
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic [b64d_pkg::RES_CNT_W-1:0]    push_n,
	input  b64d_pkg::res_t [b64d_pkg::MAX_RES-1:0] push_res,
	output logic [$clog2(DEPTH+1)-1:0]             space,
	output logic                                   head_valid,
	output b64d_pkg::res_t                         head,
	input  wire logic                              pop
);
	import b64d_pkg::*;

	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH+1);

	res_t             mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign space      = CNT_W'(DEPTH) - count_q;
	assign head_valid = count_q != '0;
	assign head       = mem_q[rd_ptr_q];

	// write up to three entries in one cycle at consecutive slots
	always_ff @(posedge clk) begin
		for (int i = 0; i < MAX_RES; i++) begin
			if (RES_CNT_W'(i) < push_n) begin
				mem_q[wr_ptr_q + PTR_W'(i)] <= push_res[i];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + PTR_W'(push_n);
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + PTR_W'(1);
			end
			count_q <= count_q + CNT_W'(push_n) - CNT_W'(pop);
		end
	end

endmodule

`default_nettype wire

// ----- rtl/base64_stream_decoder.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Streaming Base64 decoder, standard alphabet, one character per transaction.
// Input channel: in_valid / in_stall carry char_code and last_char; last_char
//   marks the final character of an encoded string.
// Output channel: out_valid / out_stall carry one result per transaction:
//   data_byte with byte_valid, run_last on the final result of a character,
//   stream_done on the final result of a string.
// Each group of four characters yields three bytes. '=' or any character
//   outside the alphabet flushes the partial group and the rest of the
//   string is dropped until last_char, which always yields a result (a marker
//   with byte_valid low when no byte is left) and clears decoder state.
// A character passes the input register, then the result queue; its first
//   result is offered once its results are written into the queue.
// Throughput: one character per cycle while in_stall is low; the output side
//   moves one result per cycle while out_stall is low, so bursts of full
//   groups are absorbed by the FIFO_DEPTH-entry result queue. A character
//   leaves the input register only when the queue has room for all of its
//   results; otherwise in_stall is raised.
// A stalled output holds its head result; the queue keeps filling behind it.
// Reset clears the decoder state, the input register and the queue.

module base64_stream_decoder #(
	parameter int FIFO_DEPTH = b64d_pkg::FIFO_DEPTH_DEF
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_stall,
	input  wire logic [7:0] char_code,
	input  wire logic       last_char,
	output logic            out_valid,
	input  wire logic       out_stall,
	output logic [7:0]      data_byte,
	output logic            byte_valid,
	output logic            run_last,
	output logic            stream_done
);
	import b64d_pkg::*;

	localparam int CNT_W = $clog2(FIFO_DEPTH+1);

	logic             valid_s1;
	logic [7:0]       char_s1;
	logic             last_s1;
	logic             adv;
	dec_t             dec;
	logic [CNT_W-1:0] space;
	res_t             head;

	// advance the input register once the queue can take every result
	assign adv      = valid_s1 && (space >= CNT_W'(dec.n_res));
	assign in_stall = valid_s1 && !adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && !in_stall) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	// payload holds while stalled
	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			char_s1 <= char_code;
			last_s1 <= last_char;
		end
	end

	b64d_decode u_decode (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (adv),
		.char_code (char_s1),
		.last_char (last_s1),
		.dec       (dec)
	);

	b64d_resq #(
		.DEPTH (FIFO_DEPTH)
	) u_resq (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_n     (adv ? dec.n_res : RES_CNT_W'(0)),
		.push_res   (dec.res),
		.space      (space),
		.head_valid (out_valid),
		.head       (head),
		.pop        (out_valid && !out_stall)
	);

	assign data_byte   = head.data_byte;
	assign byte_valid  = head.byte_valid;
	assign run_last    = head.run_last;
	assign stream_done = head.stream_done;

endmodule

`default_nettype wire

// ----- rtl/b64d_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module b64d_checker (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       in_valid,
	input wire logic       in_stall,
	input wire logic [7:0] char_code,
	input wire logic       last_char,
	input wire logic       out_valid,
	input wire logic       out_stall,
	input wire logic [7:0] data_byte,
	input wire logic       byte_valid,
	input wire logic       run_last,
	input wire logic       stream_done
);

	// a stalled result stays offered and unchanged
	`B64D_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && out_stall, out_valid && $stable(data_byte) && $stable(byte_valid) && $stable(run_last) && $stable(stream_done))

	// the end of a string also ends the results of its last character
	`B64D_ASSERT_NOW(a_done_is_last, clk, arst_n, out_valid && stream_done, run_last)

	// a result without a byte is only ever the end-of-string marker
	`B64D_ASSERT_NOW(a_empty_is_marker, clk, arst_n, out_valid && !byte_valid, stream_done && run_last && data_byte == 8'd0)

	// a stalled input holds its character
	`B64D_ASSERT_NEXT(a_in_hold, clk, arst_n, in_valid && in_stall, $stable(char_code) && $stable(last_char))

endmodule

bind base64_stream_decoder b64d_checker u_b64d_checker (.*);

`default_nettype wire
